// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property helpers with asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PCD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// shared types, codes and the score table of the posting chunk decoder
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int IdW    = 31;
	localparam int ScoreW = 21;
	localparam int IdxW   = 8;

	typedef enum logic [1:0] {
		PH_ID,
		PH_SCORE,
		PH_DONE
	} pcd_phase_t;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERLONG = 2'd1;
	localparam logic [1:0] ERR_TOO_MANY = 2'd2;

	localparam logic KIND_ID    = 1'b0;
	localparam logic KIND_SCORE = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [IdW-1:0]    doc_id;
		logic [ScoreW-1:0] score_fixed;
		logic [IdxW-1:0]   posting_index;
		logic              last;
		logic [1:0]        error_code;
	} pcd_result_t;

	typedef logic [ScoreW-1:0] score_lut_t [256];

	// round(b * 30 / 255 * 65536), filled at elaboration
	function automatic score_lut_t build_score_lut();
		score_lut_t lut;
		for (int i = 0; i < 256; i++) begin
			lut[i] = ScoreW'((i * 1966080 + 127) / 255);
		end
		return lut;
	endfunction

	localparam score_lut_t SCORE_LUT = build_score_lut();

endpackage

// File: rtl/pcd_in_if.sv
// ----------------------------------------------------------------------------
// pcd_in_if
// byte channel into the decoder: one compressed byte per transfer
// ----------------------------------------------------------------------------
interface pcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       chunk_start;

	modport source(output valid, output byte_value, output chunk_start, input ready);
	modport sink(input valid, input byte_value, input chunk_start, output ready);
endinterface

// File: rtl/pcd_out_if.sv
// ----------------------------------------------------------------------------
// pcd_out_if
// result channel out of the decoder: one id, score or error per transfer
// ----------------------------------------------------------------------------
interface pcd_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [30:0] doc_id;
	logic [20:0] score_fixed;
	logic [7:0]  posting_index;
	logic        last;
	logic [1:0]  error_code;

	modport source(output valid, output kind, output doc_id, output score_fixed,
		output posting_index, output last, output error_code, input ready);
	modport sink(input valid, input kind, input doc_id, input score_fixed,
		input posting_index, input last, input error_code, output ready);
endinterface

// File: rtl/pcd_step.sv
// ----------------------------------------------------------------------------
// pcd_step
// chunk state and the combinational decode of one byte against it
// ----------------------------------------------------------------------------
module pcd_step #(
	parameter int MAX_POSTINGS = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [7:0]              byte_value,
	input  logic                    chunk_start,
	input  logic [30:0]             last_doc_id,
	output logic                    res_valid,
	output pcd_pkg::pcd_result_t    res
);
	import pcd_pkg::*;

	localparam logic [IdxW-1:0] MaxPost = IdxW'(MAX_POSTINGS);

	pcd_phase_t     phase_q, phase_n, ph;
	logic [IdW-1:0] acc_q, acc_n, acc, acc_new, grp;
	logic [2:0]     gc_q, gc_n, gc;
	logic [IdW-1:0] prev_q, prev_n, prev, id;
	logic           have_q, have_n, have;
	logic [IdxW-1:0] total_q, total_n, total;
	logic [IdxW-1:0] scnt_q, scnt_n, scnt;
	logic [4:0]     shift_amt;
	logic           fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			acc_q   <= '0;
			gc_q    <= '0;
			prev_q  <= '0;
			have_q  <= 1'b0;
			total_q <= '0;
			scnt_q  <= '0;
		end else if (go) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			gc_q    <= gc_n;
			prev_q  <= prev_n;
			have_q  <= have_n;
			total_q <= total_n;
			scnt_q  <= scnt_n;
		end
	end

	always_comb begin
		// chunk start sees a cleared state
		ph    = chunk_start ? PH_ID : phase_q;
		acc   = chunk_start ? '0 : acc_q;
		gc    = chunk_start ? '0 : gc_q;
		prev  = chunk_start ? '0 : prev_q;
		have  = chunk_start ? 1'b0 : have_q;
		total = chunk_start ? '0 : total_q;
		scnt  = chunk_start ? '0 : scnt_q;

		// group count never passes 4, so the shift stays at or below 28
		shift_amt = 5'(gc) * 5'd7;
		grp       = {24'b0, byte_value[6:0]} << shift_amt;
		acc_new   = acc | grp;
		id        = acc_new + (have ? prev : '0);
		fin       = ({1'b0, scnt} + 9'd1) >= {1'b0, total};

		phase_n = ph;
		acc_n   = acc;
		gc_n    = gc;
		prev_n  = prev;
		have_n  = have;
		total_n = total;
		scnt_n  = scnt;
		res_valid = 1'b0;
		res       = '0;

		unique case (ph)
			PH_ID: begin
				if (byte_value[7]) begin
					if (gc >= 3'd4) begin
						phase_n           = PH_DONE;
						res_valid         = 1'b1;
						res.kind          = KIND_ID;
						res.posting_index = total;
						res.last          = 1'b1;
						res.error_code    = ERR_OVERLONG;
					end else begin
						acc_n = acc_new;
						gc_n  = gc + 3'd1;
					end
				end else begin
					acc_n     = '0;
					gc_n      = '0;
					res_valid = 1'b1;
					res.kind  = KIND_ID;
					res.posting_index = total;
					if (total >= MaxPost) begin
						phase_n        = PH_DONE;
						res.last       = 1'b1;
						res.error_code = ERR_TOO_MANY;
					end else begin
						res.doc_id = id;
						prev_n     = id;
						have_n     = 1'b1;
						total_n    = total + 1'b1;
						if (id == last_doc_id) begin
							phase_n = PH_SCORE;
						end
					end
				end
			end
			PH_SCORE: begin
				res_valid         = 1'b1;
				res.kind          = KIND_SCORE;
				res.score_fixed   = SCORE_LUT[byte_value];
				res.posting_index = scnt;
				res.last          = fin;
				scnt_n            = scnt + 1'b1;
				if (fin) begin
					phase_n = PH_DONE;
				end
			end
			default: begin
				// done: bytes are dropped until the next chunk start
			end
		endcase
	end

endmodule

// File: rtl/posting_chunk_decoder.sv
// path: a byte waits in the input register, then its result is held in the result register
// throughput: one byte per cycle; a byte leaves the input register as soon as
// the result register is free or being emptied in the same cycle
// reset: arst_n clears chunk state, last_doc_id and both valid flags at once
// ----------------------------------------------------------------------------
// posting_chunk_decoder
// varbyte delta-gap document ids followed by scaled impact scores
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module posting_chunk_decoder #(
	parameter int MAX_POSTINGS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data,
	pcd_in_if.sink      chunk,
	pcd_out_if.source   posting
);
	import pcd_pkg::*;

	logic [30:0] last_doc_id_val_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        advance;
	logic        res_valid;
	pcd_result_t res;
	logic        out_valid_q;
	pcd_result_t res_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_doc_id_val_q <= '0;
		end else if (cfg_wr_en) begin
			last_doc_id_val_q <= cfg_wr_data;
		end
	end

	assign advance     = valid_s1 && (!out_valid_q || posting.ready);
	assign chunk.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chunk.ready) begin
			valid_s1 <= chunk.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chunk.ready && chunk.valid) begin
			byte_s1  <= chunk.byte_value;
			start_s1 <= chunk.chunk_start;
		end
	end

	pcd_step #(
		.MAX_POSTINGS(MAX_POSTINGS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (advance),
		.byte_value (byte_s1),
		.chunk_start(start_s1),
		.last_doc_id(last_doc_id_val_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (posting.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign posting.valid         = out_valid_q;
	assign posting.kind          = res_q.kind;
	assign posting.doc_id        = res_q.doc_id;
	assign posting.score_fixed   = res_q.score_fixed;
	assign posting.posting_index = res_q.posting_index;
	assign posting.last          = res_q.last;
	assign posting.error_code    = res_q.error_code;

	// an error always closes the chunk
	`PCD_ASSERT_NOW(a_err_last, clk, arst_n,
		out_valid_q && (res_q.error_code != ERR_NONE), res_q.last, "error without last")
	// scores carry no id and no error
	`PCD_ASSERT_NOW(a_score_clean, clk, arst_n,
		out_valid_q && (res_q.kind == KIND_SCORE),
		(res_q.doc_id == '0) && (res_q.error_code == ERR_NONE), "dirty score result")
	// an empty result register never stalls the input side
	`PCD_ASSERT_NOW(a_no_stall, clk, arst_n,
		!out_valid_q, chunk.ready, "input stalled with free result register")
	// a byte held in the input register is not lost while stalled
	`PCD_ASSERT_NEXT(a_hold_s1, clk, arst_n,
		valid_s1 && !advance, valid_s1 && $stable(byte_s1), "input register dropped")

endmodule
